/* src/value_list_table_engine_defines.svh */
// Assertion macros used by the RTL file of the value list table engine.
`ifndef VALUE_LIST_TABLE_ENGINE_DEFINES_SVH
`define VALUE_LIST_TABLE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define VLTE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("value list table engine: assertion failed");
`define VLTE_ASSERT_NEVER(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error("value list table engine: forbidden condition seen");
`else
`define VLTE_ASSERT(label, prop)
`define VLTE_ASSERT_NEVER(label, prop)
`endif

`endif

/* src/vlte_pkg.sv */
package vlte_pkg;

	typedef logic [2:0]  opcode_t;
	typedef logic [1:0]  status_t;
	typedef logic [31:0] word_t;

	localparam opcode_t OP_APPEND   = 3'd0;
	localparam opcode_t OP_SEARCH   = 3'd1;
	localparam opcode_t OP_REMFIRST = 3'd2;
	localparam opcode_t OP_REMALL   = 3'd3;
	localparam opcode_t OP_DUMP     = 3'd4;
	localparam opcode_t OP_ASC      = 3'd5;
	localparam opcode_t OP_DESC     = 3'd6;
	localparam opcode_t OP_NONE     = 3'd7;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_FULL     = 2'd1;
	localparam status_t STAT_NOTFOUND = 2'd2;
	localparam status_t STAT_EMPTY    = 2'd3;

	localparam word_t SIGN_BIT = 32'h8000_0000;

	// Maps a signed value onto an unsigned key whose ascending order is the
	// wanted output order; the mapping is its own inverse.
	function automatic word_t sort_key(input word_t v, input logic desc);
		word_t k;
		k = v ^ SIGN_BIT;
		return desc ? ~k : k;
	endfunction

endpackage

/* src/value_list_table_engine.sv */
// Append writes the store on acceptance; search and removals scan every entry held.
// Stored readout emits the entries in stored order; sorted readouts make a full pass
// through the store per result.
// One item is taken at a time; the single-port store with registered read sets the pace.
// Reset (arst_n low) empties the list and clears the output valid at once.
`include "value_list_table_engine_defines.svh"

module value_list_table_engine
	import vlte_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // operand_value
	input  logic [2:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // position, result_value, entry_total, zero fill
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast   // last_of_run
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_DATA = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]    state_q;
	opcode_t       op_q;
	word_t         val_q;
	word_t         rd_q;
	word_t         store_q [CAPACITY];
	logic [CW-1:0] cnt_q, idx_q, wr_q, pos_q, k_q;
	logic          found_q;
	status_t       stat_q;
	logic          have_last_q, have_best_q;
	word_t         last_key_q, best_key_q;
	logic [CW-1:0] last_idx_q, best_idx_q;

	logic          out_free, accept, scan_last, match, drop, desc;
	logic          emit, app_ok;
	logic          we;
	logic [IW-1:0] wa;
	word_t         wd, key;
	logic          above, better;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign app_ok    = accept && (s_tuser == OP_APPEND) && (cnt_q < CW'(CAPACITY));
	assign out_free  = !m_tvalid || m_tready;
	assign emit      = out_free && (((state_q == S_DATA) && (op_q == OP_DUMP))
	                   || (state_q == S_EMIT) || (state_q == S_FIN));
	assign scan_last = (CW'(idx_q + 1'b1) == cnt_q);
	assign match     = (rd_q == val_q);
	assign drop      = match && ((op_q == OP_REMALL) || ((op_q == OP_REMFIRST) && !found_q));
	assign desc      = (op_q == OP_DESC);
	assign key       = sort_key(rd_q, desc);
	assign above     = !have_last_q || (key > last_key_q)
	                   || ((key == last_key_q) && (idx_q > last_idx_q));
	assign better    = !have_best_q || (key < best_key_q);

	always_comb begin
		we = 1'b0;
		wa = cnt_q[IW-1:0];
		wd = s_tdata;
		if (app_ok) begin
			we = 1'b1;
		end else if ((state_q == S_DATA) && !drop
		             && ((op_q == OP_REMFIRST) || (op_q == OP_REMALL))) begin
			we = 1'b1;
			wa = wr_q[IW-1:0];
			wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wa] <= wd;
		end
		if (state_q == S_READ) begin
			rd_q <= store_q[idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			m_tvalid    <= 1'b0;
			op_q        <= OP_NONE;
			idx_q       <= '0;
			wr_q        <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
			stat_q      <= STAT_OK;
			have_last_q <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= s_tuser;
						val_q       <= s_tdata;
						idx_q       <= '0;
						wr_q        <= '0;
						pos_q       <= '0;
						k_q         <= '0;
						found_q     <= 1'b0;
						have_last_q <= 1'b0;
						have_best_q <= 1'b0;
						if (s_tuser == OP_APPEND) begin
							state_q <= S_FIN;
							if (cnt_q < CW'(CAPACITY)) begin
								cnt_q  <= CW'(cnt_q + 1'b1);
								stat_q <= STAT_OK;
							end else begin
								stat_q <= STAT_FULL;
							end
						end else if (s_tuser == OP_NONE) begin
							state_q <= S_IDLE;
						end else if (cnt_q == '0) begin
							state_q <= S_FIN;
							stat_q  <= (s_tuser == OP_DUMP || s_tuser == OP_ASC
							            || s_tuser == OP_DESC) ? STAT_EMPTY : STAT_NOTFOUND;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (op_q == OP_DUMP) begin
						if (out_free) begin
							m_tuser  <= STAT_OK;
							m_tlast  <= scan_last;
							m_tdata  <= {3'b000, 7'(cnt_q), rd_q, 6'd0};
							idx_q    <= CW'(idx_q + 1'b1);
							state_q  <= scan_last ? S_IDLE : S_READ;
						end
					end else if (op_q == OP_ASC || op_q == OP_DESC) begin
						if (above && better) begin
							best_key_q  <= key;
							best_idx_q  <= idx_q;
							have_best_q <= 1'b1;
						end
						idx_q   <= CW'(idx_q + 1'b1);
						state_q <= scan_last ? S_EMIT : S_READ;
					end else begin
						if (match) begin
							found_q <= 1'b1;
							if (!found_q && (op_q != OP_REMALL)) begin
								pos_q <= idx_q;
							end
						end
						if (!drop) begin
							wr_q <= CW'(wr_q + 1'b1);
						end
						idx_q <= CW'(idx_q + 1'b1);
						if (scan_last) begin
							state_q <= S_FIN;
							stat_q  <= (found_q || match) ? STAT_OK : STAT_NOTFOUND;
							if (op_q != OP_SEARCH) begin
								cnt_q <= CW'(wr_q + {{(CW-1){1'b0}}, !drop});
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tuser     <= STAT_OK;
						m_tlast     <= (CW'(k_q + 1'b1) == cnt_q);
						m_tdata     <= {3'b000, 7'(cnt_q), sort_key(best_key_q, desc), 6'd0};
						last_key_q  <= best_key_q;
						last_idx_q  <= best_idx_q;
						have_last_q <= 1'b1;
						have_best_q <= 1'b0;
						idx_q       <= '0;
						k_q         <= CW'(k_q + 1'b1);
						state_q     <= (CW'(k_q + 1'b1) == cnt_q) ? S_IDLE : S_READ;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tuser  <= stat_q;
						m_tlast  <= 1'b1;
						m_tdata  <= {3'b000, 7'(cnt_q), 32'd0, 6'(pos_q)};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`VLTE_ASSERT(a_count_in_range, cnt_q <= CW'(CAPACITY))
	`VLTE_ASSERT(a_append_grows, app_ok |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
	`VLTE_ASSERT(a_scan_in_list, (state_q == S_READ || state_q == S_DATA) |-> (idx_q < cnt_q))
	`VLTE_ASSERT_NEVER(a_write_overtakes_read, (state_q == S_DATA) && (wr_q > idx_q))

endmodule
